@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the keyword spotter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KWS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/kws_pkg.sv @@
// Shared types, sizes and keyword table of the keyword spotter.
package kws_pkg;

    localparam int WINDOW_BYTES = 9;
    localparam int KW_COUNT     = 25;
    localparam int KW_MAX       = 9;
    // One cell per keyword byte position, never more than the window holds
    localparam int CELL_COUNT   = (KW_MAX < WINDOW_BYTES) ? KW_MAX : WINDOW_BYTES;

    localparam logic [7:0] UPPER_A  = 8'h41;
    localparam logic [7:0] UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Keyword lengths in bytes
    localparam int KW_LEN [KW_COUNT] = '{
        1, 4, 4, 4, 5, 7, 6, 6, 5, 7, 5, 4, 8,
        6, 6, 6, 6, 9, 6, 6, 6, 6, 6, 6, 6
    };

    // Keyword bytes, lower case, padded with zero (a zero byte never enters the chain)
    localparam logic [7:0] KW_ROM [KW_COUNT][KW_MAX] = '{
        '{8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"h", "e", "l", "p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"h", "o", "w", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "y", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "a", "t", " ", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "h", "o", "u", "l", "d", " ", 8'h00, 8'h00},
        '{"p", "l", "e", "a", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"a", "d", "v", "i", "c", "e", 8'h00, 8'h00, 8'h00},
        '{"a", "l", "e", "r", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "a", "r", "n", "i", "n", "g", 8'h00, 8'h00},
        '{"e", "r", "r", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "i", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"a", "b", "n", "o", "r", "m", "a", "l", 8'h00},
        '{8'hE5, 8'h92, 8'hA8, 8'hE8, 8'hAF, 8'hA2, 8'h00, 8'h00, 8'h00},
        '{8'hE8, 8'hAF, 8'hB7, 8'hE9, 8'h97, 8'hAE, 8'h00, 8'h00, 8'h00},
        '{8'hE6, 8'h80, 8'h8E, 8'hE4, 8'hB9, 8'h88, 8'h00, 8'h00, 8'h00},
        '{8'hE5, 8'hA6, 8'h82, 8'hE4, 8'hBD, 8'h95, 8'h00, 8'h00, 8'h00},
        '{8'hE4, 8'hB8, 8'hBA, 8'hE4, 8'hBB, 8'h80, 8'hE4, 8'hB9, 8'h88},
        '{8'hE6, 8'h98, 8'hAF, 8'hE5, 8'h90, 8'hA6, 8'h00, 8'h00, 8'h00},
        '{8'hE6, 8'hB1, 8'h82, 8'hE5, 8'h8A, 8'hA9, 8'h00, 8'h00, 8'h00},
        '{8'hE5, 8'h91, 8'h8A, 8'hE8, 8'hAD, 8'hA6, 8'h00, 8'h00, 8'h00},
        '{8'hE6, 8'h8A, 8'hA5, 8'hE8, 8'hAD, 8'hA6, 8'h00, 8'h00, 8'h00},
        '{8'hE5, 8'hBC, 8'h82, 8'hE5, 8'hB8, 8'hB8, 8'h00, 8'h00, 8'h00},
        '{8'hE6, 8'h95, 8'h85, 8'hE9, 8'h9A, 8'h9C, 8'h00, 8'h00, 8'h00},
        '{8'hE5, 8'hBB, 8'hBA, 8'hE8, 8'hAE, 8'hAE, 8'h00, 8'h00, 8'h00}
    };

    // One byte position of every keyword
    typedef logic [KW_COUNT-1:0][7:0] kws_col_t;
    // One flag per keyword
    typedef logic [KW_COUNT-1:0]      kws_vec_t;

    // Control broadcast to all cells
    typedef struct packed {
        logic shift;   // a new folded byte enters the chain
        logic clear;   // last byte of a payload: drop all partial matches
    } kws_ctl_t;

endpackage

@@ rtl/core/kws_cell.sv @@
// One byte position of the match chain: partial-match flags for all keywords.
module kws_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  kws_pkg::kws_ctl_t  ctl,
    input  logic [7:0]         cur_byte,
    input  kws_pkg::kws_col_t  col_bytes,
    input  kws_pkg::kws_vec_t  prev_match,
    output kws_pkg::kws_vec_t  cand_match,
    output kws_pkg::kws_vec_t  match
);
    import kws_pkg::*;

    kws_vec_t match_reg;
    kws_vec_t match_next;

    // Prefix through this position matches if the previous one did and this byte fits
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            cand_match[k] = prev_match[k] && (cur_byte == col_bytes[k]);
        end
    end

    always_comb
    begin
        priority if (ctl.clear)
            match_next = '0;
        else if (ctl.shift)
            match_next = cand_match;
        else
            match_next = match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= '0;
        else
            match_reg <= match_next;
    end

    assign match = match_reg;

endmodule

@@ rtl/core/case_insensitive_keyword_spotter.sv @@
// Top level of the case-insensitive keyword spotter.
//
// Usage:
//   Input channel (data_byte, last, byte_valid/byte_ready) takes one payload
//   byte per request. ASCII capitals are folded to lower case; a zero byte
//   stops the scan and later bytes of the same payload are ignored.
//   Output channel (ask, ask_valid/ask_ready) gives one flag per payload,
//   issued for the request marked last: 1 if any keyword was seen.
// Throughput: one byte per cycle while byte_ready is high. Each nonzero byte
//   before a stop updates a row of nine match cells, one per keyword byte position.
// Latency: the flag is valid the cycle after its last byte is accepted.
// Stall: the flag waits in an output register; byte_ready stays high while
//   that register is empty or is being read in the same cycle. While a flag
//   sits unread, no byte of any kind is taken.
// Reset: clears the cells, the hit and stop flags and the output register;
//   the block is ready as soon as reset ends. State also clears after each
//   last byte.
`include "assert_macros.svh"

module case_insensitive_keyword_spotter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       last,
    input  logic       byte_valid,
    output logic       byte_ready,
    output logic       ask,
    output logic       ask_valid,
    input  logic       ask_ready
);
    import kws_pkg::*;

    kws_ctl_t   ctl;
    logic       accept;
    logic       active;
    logic       hit_now;
    logic [7:0] folded;

    logic hit_reg,       hit_next;
    logic stop_reg,      stop_next;
    logic out_valid_reg, out_valid_next;
    logic ask_reg,       ask_next;

    kws_col_t col    [CELL_COUNT];
    kws_vec_t prev   [CELL_COUNT];
    kws_vec_t cand   [CELL_COUNT];
    kws_vec_t match  [CELL_COUNT];
    kws_vec_t hit_vec;

    // Handshake
    assign byte_ready = !out_valid_reg || ask_ready;
    assign accept     = byte_valid && byte_ready;
    assign active     = !stop_reg;

    // Fold ASCII capitals
    assign folded = ((data_byte >= UPPER_A) && (data_byte <= UPPER_Z)) ?
                    (data_byte | CASE_BIT) : data_byte;

    assign ctl.shift = accept && active && (data_byte != 8'h00);
    assign ctl.clear = accept && last;

    // Cell row: each cell takes the partial matches of its left neighbor
    for (genvar j = 0; j < CELL_COUNT; j++)
    begin : g_cell
        for (genvar k = 0; k < KW_COUNT; k++)
        begin : g_col
            assign col[j][k] = KW_ROM[k][j];
        end

        if (j == 0)
        begin : g_head
            assign prev[j] = '1;
        end
        else
        begin : g_link
            assign prev[j] = match[j-1];
        end

        kws_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cur_byte   (folded),
            .col_bytes  (col[j]),
            .prev_match (prev[j]),
            .cand_match (cand[j]),
            .match      (match[j])
        );
    end

    // A keyword completes at the cell of its last byte
    for (genvar k = 0; k < KW_COUNT; k++)
    begin : g_hit
        if (KW_LEN[k] <= CELL_COUNT)
        begin : g_fit
            assign hit_vec[k] = cand[KW_LEN[k]-1][k];
        end
        else
        begin : g_nofit
            assign hit_vec[k] = 1'b0;
        end
    end

    assign hit_now = ctl.shift && (|hit_vec);

    // Sticky hit and stop flags
    always_comb
    begin
        hit_next  = hit_reg;
        stop_next = stop_reg;
        if (accept)
        begin
            if (last)
            begin
                hit_next  = 1'b0;
                stop_next = 1'b0;
            end
            else
            begin
                hit_next  = hit_reg || hit_now;
                stop_next = stop_reg || (data_byte == 8'h00);
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        ask_next       = ask_reg;
        priority if (accept && last)
        begin
            out_valid_next = 1'b1;
            ask_next       = hit_reg || hit_now;
        end
        else if (ask_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ask_reg       <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
            ask_reg       <= ask_next;
        end
    end

    assign ask       = ask_reg;
    assign ask_valid = out_valid_reg;

    // Checks
    `KWS_ASSERT(a_no_overwrite, !(out_valid_reg && !ask_ready && byte_ready), "byte taken while flag unread")
    `KWS_ASSERT_NEXT(a_flag_issued, accept && last, ask_valid, "no flag after last byte")
    `KWS_ASSERT_NEXT(a_state_cleared, accept && last, !hit_reg && !stop_reg, "state not cleared")
    `KWS_ASSERT(a_stopped_frozen, !(stop_reg && ctl.shift), "chain advanced after zero byte")

endmodule

@@ sim/tb_case_insensitive_keyword_spotter.sv @@
`timescale 1ns / 100ps
// Testbench for the case-insensitive keyword spotter: directed and random payloads checked against a scan model.
module tb_case_insensitive_keyword_spotter;

    localparam int SPAN        = 9;     // bytes in the match window
    localparam int PHRASES     = 25;    // keywords in the table
    localparam int ITEM_GOAL   = 1350;  // payload bytes to send
    localparam int CALM_TAIL   = 120;   // last bytes sent without idling
    localparam int QUIET_LIMIT = 2000;  // cycles without any handshake

    typedef struct packed {
        logic [7:0] value;
        logic       closes;   // final byte of its payload
    } msg_byte_t;

    typedef enum int {
        CHUNK_WORD,     // a whole keyword, random case
        CHUNK_STUB,     // a keyword missing its final byte
        CHUNK_TEXT,     // letters and spaces
        CHUNK_BINARY,   // any nonzero byte
        CHUNK_ZERO      // terminator byte placed anywhere in a payload
    } chunk_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic [7:0] data_byte  = 8'h00;
    logic       last       = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    logic       ask;
    logic       ask_valid;
    logic       ask_ready  = 1'b0;

    case_insensitive_keyword_spotter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .last       (last),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .ask        (ask),
        .ask_valid  (ask_valid),
        .ask_ready  (ask_ready)
    );

    always #5 clk = ~clk;

    msg_byte_t         byte_queue[$];
    logic              ask_expect[$];
    msg_byte_t         next_req;
    logic              expected_ask;

    // scan model state
    logic [SPAN*8-1:0] window     = '0;
    logic              hit_seen   = 1'b0;
    logic              halted     = 1'b0;

    logic              byte_taken = 1'b0;
    logic              stuck      = 1'b0;
    int                gap_left   = 0;
    int                stall_left = 0;
    int                quiet      = 0;
    int                errors     = 0;
    int                n_bytes    = 0;
    int                n_msgs     = 0;
    int                n_hits     = 0;
    int                n_halts    = 0;

    // Keyword table, right-aligned: the final keyword byte sits in bits 7:0
    function automatic void phrase(input int k, output int len, output logic [71:0] bits);
        case (k)
            0:       begin len = 1; bits = 72'h3F;                   end
            1:       begin len = 4; bits = "help";                   end
            2:       begin len = 4; bits = "how ";                   end
            3:       begin len = 4; bits = "why ";                   end
            4:       begin len = 5; bits = "what ";                  end
            5:       begin len = 7; bits = "should ";                end
            6:       begin len = 6; bits = "please";                 end
            7:       begin len = 6; bits = "advice";                 end
            8:       begin len = 5; bits = "alert";                  end
            9:       begin len = 7; bits = "warning";                end
            10:      begin len = 5; bits = "error";                  end
            11:      begin len = 4; bits = "fail";                   end
            12:      begin len = 8; bits = "abnormal";               end
            13:      begin len = 6; bits = 72'hE592A8_E8AFA2;        end
            14:      begin len = 6; bits = 72'hE8AFB7_E997AE;        end
            15:      begin len = 6; bits = 72'hE6808E_E4B988;        end
            16:      begin len = 6; bits = 72'hE5A682_E4BD95;        end
            17:      begin len = 9; bits = 72'hE4B8BA_E4BB80_E4B988; end
            18:      begin len = 6; bits = 72'hE698AF_E590A6;        end
            19:      begin len = 6; bits = 72'hE6B182_E58AA9;        end
            20:      begin len = 6; bits = 72'hE5918A_E8ADA6;        end
            21:      begin len = 6; bits = 72'hE68AA5_E8ADA6;        end
            22:      begin len = 6; bits = 72'hE5BC82_E5B8B8;        end
            23:      begin len = 6; bits = 72'hE69585_E99A9C;        end
            default: begin len = 6; bits = 72'hE5BBBA_E8AEAE;        end
        endcase
    endfunction

    // Fold, shift and compare one accepted byte; a final byte yields the expected flag
    task automatic spot_byte(input msg_byte_t b);
        logic [7:0]  v;
        logic [71:0] bits;
        int          len;
        v = b.value;
        if (!halted) begin
            if (v == 8'h00) begin
                halted = 1'b1;
                n_halts++;
            end
            else begin
                if (v >= "A" && v <= "Z")
                    v = v + 8'h20;
                window = {window[SPAN*8-9:0], v};
                for (int k = 0; k < PHRASES; k++) begin
                    phrase(k, len, bits);
                    if ((window & ({(SPAN*8){1'b1}} >> ((SPAN - len) * 8))) == bits)
                        hit_seen = 1'b1;
                end
            end
        end
        if (b.closes) begin
            ask_expect.push_back(hit_seen);
            n_msgs++;
            if (hit_seen)
                n_hits++;
            window   = '0;
            hit_seen = 1'b0;
            halted   = 1'b0;
        end
    endtask

    task automatic put(input logic [7:0] v, input logic closes);
        byte_queue.push_back(msg_byte_t'{v, closes});
    endtask

    function automatic logic [7:0] text_byte();
        int         r;
        logic [7:0] v;
        r = $urandom_range(0, 26);
        if (r == 26)
            return " ";
        v = "a" + r[7:0];
        if ($urandom_range(0, 1) == 1)
            v = v - 8'h20;
        return v;
    endfunction

    // Keyword bytes with random capitals; cut drops the final byte
    task automatic put_phrase(input int k, input bit cut);
        int          len;
        int          count;
        logic [71:0] bits;
        logic [7:0]  v;
        phrase(k, len, bits);
        count = cut ? len - 1 : len;
        for (int i = 0; i < count; i++) begin
            v = bits[(len - 1 - i) * 8 +: 8];
            if (v >= "a" && v <= "z" && $urandom_range(0, 1) == 1)
                v = v - 8'h20;
            put(v, 1'b0);
        end
    endtask

    task automatic random_payload();
        int     chunks;
        int     r;
        int     start;
        chunk_t kind;
        start  = byte_queue.size();
        chunks = $urandom_range(1, 4);
        for (int c = 0; c < chunks; c++) begin
            r = $urandom_range(0, 99);
            if (r < 30)      kind = CHUNK_WORD;
            else if (r < 45) kind = CHUNK_STUB;
            else if (r < 75) kind = CHUNK_TEXT;
            else if (r < 95) kind = CHUNK_BINARY;
            else             kind = CHUNK_ZERO;
            case (kind)
                CHUNK_WORD:   put_phrase($urandom_range(0, PHRASES - 1), 1'b0);
                CHUNK_STUB:   put_phrase($urandom_range(0, PHRASES - 1), 1'b1);
                CHUNK_TEXT:   repeat ($urandom_range(1, 8)) put(text_byte(), 1'b0);
                CHUNK_BINARY: repeat ($urandom_range(1, 6)) put(8'($urandom_range(1, 255)), 1'b0);
                default:      put(8'h00, 1'b0);
            endcase
        end
        // mark the payload end; a stub of the one-byte keyword may leave nothing
        if (byte_queue.size() == start)
            put(text_byte(), 1'b1);
        else
            byte_queue[byte_queue.size() - 1].closes = 1'b1;
    endtask

    // Request driver: one byte per handshake, random gaps until the tail
    always @(negedge clk) begin
        if (rst_n) begin
            if (!byte_valid || byte_taken) begin
                if (gap_left > 0) begin
                    byte_valid <= 1'b0;
                    gap_left--;
                end
                else if (byte_queue.size() == 0) begin
                    byte_valid <= 1'b0;
                end
                else if (byte_queue.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
                    byte_valid <= 1'b0;
                    gap_left = $urandom_range(0, 11);
                end
                else begin
                    next_req = byte_queue.pop_front();
                    data_byte  <= next_req.value;
                    last       <= next_req.closes;
                    byte_valid <= 1'b1;
                end
            end
            // flag receiver back-pressure
            if (stall_left > 0) begin
                ask_ready <= 1'b0;
                stall_left--;
            end
            else if (byte_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                ask_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end
            else begin
                ask_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on accepted bytes, check flags, watch for a hang
    always @(posedge clk) begin
        if (rst_n) begin
            byte_taken <= byte_valid && byte_ready;
            if (byte_valid && byte_ready) begin
                spot_byte(msg_byte_t'{data_byte, last});
                n_bytes++;
            end
            if (ask_valid && ask_ready) begin
                if (ask_expect.size() == 0) begin
                    $display("%0t: ask mismatch, expected none, got %0b", $time, ask);
                    errors++;
                end
                else begin
                    expected_ask = ask_expect.pop_front();
                    if (ask !== expected_ask) begin
                        $display("%0t: ask mismatch, expected %0b, got %0b",
                                 $time, expected_ask, ask);
                        errors++;
                    end
                end
            end
            if ((byte_valid && byte_ready) || (ask_valid && ask_ready))
                quiet <= 0;
            else if (quiet + 1 >= QUIET_LIMIT)
                stuck <= 1'b1;
            else
                quiet <= quiet + 1;
        end
    end

    initial begin
        // directed payloads
        put(8'h00, 1'b1);                               // payload of a single zero byte
        put("?", 1'b1);                                 // one-byte keyword on the final byte
        put("H", 1'b0); put("E", 1'b0); put("L", 1'b0); put("P", 1'b1);   // all capitals
        put(8'h40, 1'b0); put(8'h5B, 1'b0); put(8'hFF, 1'b0); put(8'h01, 1'b1);
        // zero stops the scan: the later bytes would complete two keywords
        put("f", 1'b0); put("a", 1'b0); put(8'h00, 1'b0);
        put("i", 1'b0); put("l", 1'b0); put("?", 1'b1);
        put_phrase(17, 1'b0);                           // longest keyword fills the window
        byte_queue[byte_queue.size() - 1].closes = 1'b1;

        while (byte_queue.size() < ITEM_GOAL)
            random_payload();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(byte_queue.size() == 0 && !byte_valid && ask_expect.size() == 0) && !stuck)
            @(negedge clk);

        if (stuck) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else begin
            repeat (10) @(posedge clk);
            $display("summary: %0d bytes in %0d payloads, %0d with a keyword hit",
                     n_bytes, n_msgs, n_hits);
            $display("summary: %0d payloads stopped early by a zero byte, %0d mismatches",
                     n_halts, errors);
            if (errors == 0)
                $display("tb: success");
            else
                $display("tb: failure");
            $finish;
        end
    end

endmodule
